/* sv/bcdc_pkg.sv */
// Shared types, constants and the filter function of the brake chopper duty controller.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package bcdc_pkg;

    localparam int TIMEOUT_TICKS = 2000;
    localparam int TICK_W        = $clog2(TIMEOUT_TICKS + 2);

    localparam int ACC_W  = 34;
    localparam int DUTY_W = 17;
    localparam int NUM_W  = 50;
    localparam int DEN_W  = 33;
    localparam int QUO_W  = 17;
    localparam int CNT_W  = 5;

    localparam logic [15:0] K_TEMP = 16'd3277;
    localparam logic [15:0] K_CURR = 16'd655;
    localparam logic [15:0] K_VOLT = 16'd32768;

    localparam logic [DUTY_W-1:0] ONE_Q16    = 17'h10000;
    localparam logic [DUTY_W-1:0] AUTO_MIN   = 17'd1311;
    localparam logic [DUTY_W-1:0] OT_LIMIT   = 17'd58983;
    localparam logic [DUTY_W-1:0] ACTIVE_MIN = 17'd66;

    localparam logic [2:0] REG_TEMP_START = 3'd0;
    localparam logic [2:0] REG_TEMP_END   = 3'd1;
    localparam logic [2:0] REG_VOLT_START = 3'd2;
    localparam logic [2:0] REG_VOLT_END   = 3'd3;
    localparam logic [2:0] REG_AUTO_START = 3'd4;
    localparam logic [2:0] REG_AUTO_FULL  = 3'd5;
    localparam logic [2:0] REG_AUTO_FRAC  = 3'd6;
    localparam logic [2:0] REG_PWM_PERIOD = 3'd7;

    localparam logic [1:0] DIV_TEMP = 2'd0;
    localparam logic [1:0] DIV_VOLT = 2'd1;
    localparam logic [1:0] DIV_AUTO = 2'd2;

    typedef struct packed {
        logic signed [15:0] temp_start;
        logic signed [15:0] temp_end;
        logic [15:0]        volt_start;
        logic [15:0]        volt_end;
        logic [15:0]        auto_start;
        logic [15:0]        auto_full;
        logic [16:0]        auto_frac;
        logic [15:0]        pwm_period;
    } cfg_t;

    typedef struct packed {
        logic       capture;
        logic       filt;
        logic       div_start;
        logic [1:0] div_sel;
        logic       tf_store;
        logic       vf_store;
        logic       ceil_upd;
        logic       auto_mul;
        logic       auto_apply;
        logic       cmp_calc;
        logic       out_load;
    } cmd_t;

    // One step of the first-order low-pass: acc - floor(k * (acc - sample) / 65536).
    function automatic logic signed [ACC_W-1:0] lowpass(
        input logic signed [ACC_W-1:0] acc,
        input logic signed [ACC_W-1:0] smp,
        input logic [15:0]             k
    );
        logic signed [ACC_W:0]   d;
        logic signed [ACC_W+17:0] p;
        d = (ACC_W+1)'(acc) - (ACC_W+1)'(smp);
        p = (ACC_W+18)'(d) * $signed({1'b0, k});
        return acc - ACC_W'(p >>> 16);
    endfunction

endpackage

`default_nettype wire

/* sv/bcdc_div.sv */
// Shared restoring divider of the duty controller, one quotient bit per cycle.
// Depends on bcdc_pkg for widths; the quotient must be known to fit QUO_W bits.
`default_nettype none

module bcdc_div (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic [bcdc_pkg::NUM_W-1:0] num,
    input  wire logic [bcdc_pkg::DEN_W-1:0] den,
    output logic                          done,
    output logic [bcdc_pkg::QUO_W-1:0]    quo
);
    import bcdc_pkg::*;

    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [QUO_W-1:0] bits_reg, bits_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;
    logic             ge;

    assign trial = {rem_reg, bits_reg[QUO_W-1]};
    assign ge    = trial >= {1'b0, den};

    always_comb
    begin
        rem_next  = rem_reg;
        bits_next = bits_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = num[NUM_W-1:QUO_W];
            bits_next = num[QUO_W-1:0];
            cnt_next  = CNT_W'(QUO_W);
        end
        else if (cnt_reg != '0)
        begin
            // Numerator bits shift out of the top while quotient bits fill from below.
            rem_next  = ge ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
            bits_next = {bits_reg[QUO_W-2:0], ge};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        bits_reg <= bits_next;
    end

    assign done = done_reg;
    assign quo  = bits_reg;

endmodule

`default_nettype wire

/* sv/bcdc_dpath.sv */
// Datapath of the duty controller: filters, derating factors, duty state and result registers.
// Depends on bcdc_pkg and bcdc_div; driven by commands from bcdc_ctrl.
`default_nettype none

module bcdc_dpath (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire bcdc_pkg::cmd_t      cmd,
    input  wire bcdc_pkg::cfg_t      cfg,
    input  wire logic                command,
    input  wire logic signed [15:0]  temp_a,
    input  wire logic signed [15:0]  temp_b,
    input  wire logic signed [15:0]  temp_c,
    input  wire logic signed [15:0]  input_current,
    input  wire logic [15:0]         input_voltage,
    input  wire logic [16:0]         manual_duty,
    output logic                     div_done,
    output logic [15:0]              compare_value,
    output logic [16:0]              duty_now,
    output logic [16:0]              duty_limit,
    output logic                     over_temp_led,
    output logic                     active_led,
    output logic signed [15:0]       current_filtered,
    output logic [15:0]              voltage_filtered,
    output logic signed [15:0]       temp_filtered
);
    import bcdc_pkg::*;

    logic signed [ACC_W-1:0] acc_t_reg, acc_c_reg, acc_v_reg;
    logic [DUTY_W-1:0]       duty_reg, ceil_reg, tf_reg, vf_reg;
    logic [TICK_W-1:0]       ticks_reg;
    logic signed [15:0]      tmax_reg, curr_reg;
    logic [15:0]             volt_reg;
    logic [NUM_W-1:0]        prod_reg;
    logic [15:0]             cmpv_reg;

    logic [15:0]       cmp_out_reg;
    logic [16:0]       duty_out_reg, lim_out_reg;
    logic              ot_out_reg, act_out_reg;
    logic [15:0]       curf_out_reg, volf_out_reg, tmpf_out_reg;

    logic signed [15:0]      tmax_ab, tmax_abc;
    logic signed [ACC_W-1:0] ts, te, vs, ve, as0, as1;
    logic signed [ACC_W-1:0] d_temp, d_volt, d_auto;
    logic [NUM_W-1:0]        div_num;
    logic [DEN_W-1:0]        div_den;
    logic [QUO_W-1:0]        quo;
    logic [DUTY_W-1:0]       tf_val, vf_val, ceil_min, auto_val;
    logic [DUTY_W-1:0]       tick_duty;
    logic [TICK_W-1:0]       tick_cnt;
    logic                    auto_on;
    logic [31:0]             cmp_prod;

    assign tmax_ab  = (temp_b > temp_a) ? temp_b : temp_a;
    assign tmax_abc = (temp_c > tmax_ab) ? temp_c : tmax_ab;

    assign ts  = {{2{cfg.temp_start[15]}}, cfg.temp_start, 16'b0};
    assign te  = {{2{cfg.temp_end[15]}}, cfg.temp_end, 16'b0};
    assign vs  = {2'b0, cfg.volt_start, 16'b0};
    assign ve  = {2'b0, cfg.volt_end, 16'b0};
    assign as0 = {2'b0, cfg.auto_start, 16'b0};
    assign as1 = {2'b0, cfg.auto_full, 16'b0};

    assign d_temp = te - acc_t_reg;
    assign d_volt = acc_v_reg - ve;
    assign d_auto = acc_v_reg - as0;

    always_comb
    begin
        unique case (cmd.div_sel)
            DIV_TEMP:
            begin
                div_num = {1'b0, d_temp[DEN_W-1:0], 16'b0};
                div_den = DEN_W'(te - ts);
            end
            DIV_VOLT:
            begin
                div_num = {1'b0, d_volt[DEN_W-1:0], 16'b0};
                div_den = DEN_W'(vs - ve);
            end
            DIV_AUTO:
            begin
                div_num = prod_reg;
                div_den = DEN_W'(as1 - as0);
            end
            default:
            begin
                div_num = prod_reg;
                div_den = '0;
            end
        endcase
    end

    bcdc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (quo)
    );

    // Curve ends take priority over the quotient, which only covers the sloped part.
    always_comb
    begin
        priority if (acc_t_reg < ts)
            tf_val = ONE_Q16;
        else if (acc_t_reg > te)
            tf_val = '0;
        else if (te == ts)
            tf_val = ONE_Q16;
        else
            tf_val = quo;

        priority if (acc_v_reg > vs)
            vf_val = ONE_Q16;
        else if (acc_v_reg < ve)
            vf_val = '0;
        else if (ve == vs)
            vf_val = ONE_Q16;
        else
            vf_val = quo;

        priority if (acc_v_reg > as1 || as1 == as0)
            auto_val = cfg.auto_frac;
        else
            auto_val = quo;
    end

    assign auto_on  = (cfg.auto_frac >= AUTO_MIN) && !(acc_v_reg < as0) && (auto_val != '0);
    assign ceil_min = (tf_reg < vf_reg) ? tf_reg : vf_reg;

    // Period times duty stays below 2^32, so the compare count is bits 31:16.
    assign cmp_prod = cfg.pwm_period * duty_reg;

    always_comb
    begin
        tick_cnt  = ticks_reg + 1'b1;
        tick_duty = duty_reg;
        if (duty_reg > ceil_min)
        begin
            tick_duty = ceil_min;
            tick_cnt  = '0;
        end
        if (tick_cnt > TICK_W'(TIMEOUT_TICKS))
        begin
            tick_duty = '0;
            tick_cnt  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_t_reg <= '0;
            acc_c_reg <= '0;
            acc_v_reg <= '0;
            duty_reg  <= '0;
            ceil_reg  <= ONE_Q16;
            ticks_reg <= '0;
        end
        else
        begin
            if (cmd.capture && command)
            begin
                duty_reg  <= (manual_duty > ceil_reg) ? ceil_reg : manual_duty;
                ticks_reg <= '0;
            end
            if (cmd.filt)
            begin
                acc_t_reg <= lowpass(acc_t_reg, {{2{tmax_reg[15]}}, tmax_reg, 16'b0}, K_TEMP);
                acc_c_reg <= lowpass(acc_c_reg, {{2{curr_reg[15]}}, curr_reg, 16'b0}, K_CURR);
                acc_v_reg <= lowpass(acc_v_reg, {2'b0, volt_reg, 16'b0}, K_VOLT);
            end
            if (cmd.ceil_upd)
            begin
                ceil_reg  <= ceil_min;
                duty_reg  <= tick_duty;
                ticks_reg <= tick_cnt;
            end
            if (cmd.auto_apply && auto_on)
            begin
                duty_reg  <= (auto_val > ceil_reg) ? ceil_reg : auto_val;
                ticks_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            tmax_reg <= tmax_abc;
            curr_reg <= input_current;
            volt_reg <= input_voltage;
        end
        if (cmd.tf_store)
            tf_reg <= tf_val;
        if (cmd.vf_store)
            vf_reg <= vf_val;
        if (cmd.auto_mul)
            prod_reg <= NUM_W'(d_auto[DEN_W-1:0] * cfg.auto_frac);
        if (cmd.cmp_calc)
            cmpv_reg <= cmp_prod[31:16];
        if (cmd.out_load)
        begin
            cmp_out_reg  <= cmpv_reg;
            duty_out_reg <= duty_reg;
            lim_out_reg  <= ceil_reg;
            ot_out_reg   <= tf_reg < OT_LIMIT;
            act_out_reg  <= duty_reg >= ACTIVE_MIN;
            curf_out_reg <= acc_c_reg[31:16];
            volf_out_reg <= acc_v_reg[31:16];
            tmpf_out_reg <= acc_t_reg[31:16];
        end
    end

    assign compare_value    = cmp_out_reg;
    assign duty_now         = duty_out_reg;
    assign duty_limit       = lim_out_reg;
    assign over_temp_led    = ot_out_reg;
    assign active_led       = act_out_reg;
    assign current_filtered = curf_out_reg;
    assign voltage_filtered = volf_out_reg;
    assign temp_filtered    = tmpf_out_reg;

endmodule

`default_nettype wire

/* sv/bcdc_ctrl.sv */
// Sequencer of the duty controller: steps one request through filter (ticks only), divisions and result.
// Depends on bcdc_pkg; drives bcdc_dpath through a command struct.
`default_nettype none

module bcdc_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           item_valid,
    input  wire logic           command,
    input  wire logic           result_stall,
    input  wire logic           div_done,
    output logic                item_stall,
    output logic                result_valid,
    output bcdc_pkg::cmd_t      cmd
);
    import bcdc_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_FILT   = 4'd1;
    localparam logic [3:0] S_TSTART = 4'd2;
    localparam logic [3:0] S_TWAIT  = 4'd3;
    localparam logic [3:0] S_VSTART = 4'd4;
    localparam logic [3:0] S_VWAIT  = 4'd5;
    localparam logic [3:0] S_CEIL   = 4'd6;
    localparam logic [3:0] S_AMUL   = 4'd7;
    localparam logic [3:0] S_ASTART = 4'd8;
    localparam logic [3:0] S_AWAIT  = 4'd9;
    localparam logic [3:0] S_CMP    = 4'd10;
    localparam logic [3:0] S_DONE   = 4'd11;

    logic [3:0] state_reg, state_next;
    logic       manual_reg, manual_next;
    logic       valid_reg, valid_next;
    logic       slot_free;

    assign slot_free = !valid_reg || !result_stall;

    always_comb
    begin
        state_next  = state_reg;
        manual_next = manual_reg;
        valid_next  = valid_reg && result_stall;
        cmd         = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.capture = 1'b1;
                    manual_next = command;
                    state_next  = command ? S_TSTART : S_FILT;
                end
            end
            S_FILT:
            begin
                cmd.filt   = 1'b1;
                state_next = S_TSTART;
            end
            S_TSTART:
            begin
                cmd.div_sel   = DIV_TEMP;
                cmd.div_start = 1'b1;
                state_next    = S_TWAIT;
            end
            S_TWAIT:
            begin
                cmd.div_sel = DIV_TEMP;
                if (div_done)
                begin
                    cmd.tf_store = 1'b1;
                    state_next   = manual_reg ? S_CMP : S_VSTART;
                end
            end
            S_VSTART:
            begin
                cmd.div_sel   = DIV_VOLT;
                cmd.div_start = 1'b1;
                state_next    = S_VWAIT;
            end
            S_VWAIT:
            begin
                cmd.div_sel = DIV_VOLT;
                if (div_done)
                begin
                    cmd.vf_store = 1'b1;
                    state_next   = S_CEIL;
                end
            end
            S_CEIL:
            begin
                cmd.ceil_upd = 1'b1;
                state_next   = S_AMUL;
            end
            S_AMUL:
            begin
                cmd.auto_mul = 1'b1;
                state_next   = S_ASTART;
            end
            S_ASTART:
            begin
                cmd.div_sel   = DIV_AUTO;
                cmd.div_start = 1'b1;
                state_next    = S_AWAIT;
            end
            S_AWAIT:
            begin
                cmd.div_sel = DIV_AUTO;
                if (div_done)
                begin
                    cmd.auto_apply = 1'b1;
                    state_next     = S_CMP;
                end
            end
            S_CMP:
            begin
                cmd.cmp_calc = 1'b1;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    cmd.out_load = 1'b1;
                    valid_next   = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            manual_reg <= 1'b0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            manual_reg <= manual_next;
            valid_reg  <= valid_next;
        end
    end

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = valid_reg;

endmodule

`default_nettype wire

/* sv/brake_chopper_duty_control_top.sv */
// Brake chopper duty controller: a tick request filters the hottest of three temperatures,
// the input current and the input voltage, derates the duty ceiling on temperature and
// undervoltage, enforces a 2000-tick timeout and optional voltage-driven automatic duty; a
// manual request sets a clamped duty. One request is processed at a time. A tick makes three
// passes through the shared 17-step divider and a manual set one; the next request can be
// accepted once the result is loaded into the output register. A finished result waits in
// an output register while the next request is taken. Configuration registers sit on the
// APB port at byte address 4*i.
// Depends on bcdc_pkg, bcdc_ctrl, bcdc_dpath and bcdc_div.
`default_nettype none

module brake_chopper_duty_control_top (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  wire logic               item_valid,
    output logic                    item_stall,
    input  wire logic               command,
    input  wire logic signed [15:0] temp_a,
    input  wire logic signed [15:0] temp_b,
    input  wire logic signed [15:0] temp_c,
    input  wire logic signed [15:0] input_current,
    input  wire logic [15:0]        input_voltage,
    input  wire logic [16:0]        manual_duty,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output logic [15:0]             compare_value,
    output logic [16:0]             duty_now,
    output logic [16:0]             duty_limit,
    output logic                    over_temp_led,
    output logic                    active_led,
    output logic signed [15:0]      current_filtered,
    output logic [15:0]             voltage_filtered,
    output logic signed [15:0]      temp_filtered
);
    import bcdc_pkg::*;

    cfg_t       cfg_reg;
    cmd_t       cmd;
    logic       div_done;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.temp_start <= 16'sd1280;
            cfg_reg.temp_end   <= 16'sd1600;
            cfg_reg.volt_start <= 16'd1280;
            cfg_reg.volt_end   <= 16'd960;
            cfg_reg.auto_start <= 16'd0;
            cfg_reg.auto_full  <= 16'd0;
            cfg_reg.auto_frac  <= 17'd0;
            cfg_reg.pwm_period <= 16'd1066;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_TEMP_START: cfg_reg.temp_start <= pwdata[15:0];
                REG_TEMP_END:   cfg_reg.temp_end   <= pwdata[15:0];
                REG_VOLT_START: cfg_reg.volt_start <= pwdata[15:0];
                REG_VOLT_END:   cfg_reg.volt_end   <= pwdata[15:0];
                REG_AUTO_START: cfg_reg.auto_start <= pwdata[15:0];
                REG_AUTO_FULL:  cfg_reg.auto_full  <= pwdata[15:0];
                REG_AUTO_FRAC:  cfg_reg.auto_frac  <= pwdata[16:0];
                REG_PWM_PERIOD: cfg_reg.pwm_period <= pwdata[15:0];
                default:        cfg_reg.pwm_period <= cfg_reg.pwm_period;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_TEMP_START: prdata = {16'b0, cfg_reg.temp_start};
            REG_TEMP_END:   prdata = {16'b0, cfg_reg.temp_end};
            REG_VOLT_START: prdata = {16'b0, cfg_reg.volt_start};
            REG_VOLT_END:   prdata = {16'b0, cfg_reg.volt_end};
            REG_AUTO_START: prdata = {16'b0, cfg_reg.auto_start};
            REG_AUTO_FULL:  prdata = {16'b0, cfg_reg.auto_full};
            REG_AUTO_FRAC:  prdata = {15'b0, cfg_reg.auto_frac};
            REG_PWM_PERIOD: prdata = {16'b0, cfg_reg.pwm_period};
            default:        prdata = '0;
        endcase
    end

    bcdc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .command      (command),
        .result_stall (result_stall),
        .div_done     (div_done),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .cmd          (cmd)
    );

    bcdc_dpath u_dpath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .cfg              (cfg_reg),
        .command          (command),
        .temp_a           (temp_a),
        .temp_b           (temp_b),
        .temp_c           (temp_c),
        .input_current    (input_current),
        .input_voltage    (input_voltage),
        .manual_duty      (manual_duty),
        .div_done         (div_done),
        .compare_value    (compare_value),
        .duty_now         (duty_now),
        .duty_limit       (duty_limit),
        .over_temp_led    (over_temp_led),
        .active_led       (active_led),
        .current_filtered (current_filtered),
        .voltage_filtered (voltage_filtered),
        .temp_filtered    (temp_filtered)
    );

`ifndef SYNTH
    // The applied duty never exceeds the derating ceiling reported with it.
    a_duty_under_limit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> duty_now <= duty_limit)
        else $error("duty above ceiling");

    // A request is worked on alone, so the cycle after acceptance is stalled.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
        else $error("request accepted while busy");

    // Zero duty gives a zero compare count and a dark activity LED.
    a_zero_duty: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && duty_now == 17'd0 |-> compare_value == 16'd0 && !active_led)
        else $error("zero duty gives nonzero output");
`endif

endmodule

`default_nettype wire

/* bench/brake_chopper_duty_control_top_tb.sv */
// Testbench for the brake chopper duty controller: drives tick and manual-set requests,
// writes the registers over the APB port, and checks every result against a local model.
// Depends on bcdc_pkg and brake_chopper_duty_control_top.
`default_nettype none

module brake_chopper_duty_control_top_tb;
    import bcdc_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int HOLD_TICKS  = 300;

    typedef struct {
        logic [15:0] cmp;
        logic [16:0] duty;
        logic [16:0] lim;
        logic        ot;
        logic        act;
        logic [15:0] cur;
        logic [15:0] volt;
        logic [15:0] temp;
    } duty_result_t;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [4:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;
    logic item_valid, item_stall;
    logic command;
    logic signed [15:0] temp_a, temp_b, temp_c, input_current;
    logic [15:0] input_voltage;
    logic [16:0] manual_duty;
    logic result_valid, result_stall;
    logic [15:0] compare_value;
    logic [16:0] duty_now, duty_limit;
    logic over_temp_led, active_led;
    logic signed [15:0] current_filtered, temp_filtered;
    logic [15:0] voltage_filtered;

    brake_chopper_duty_control_top DUT (.*);

    // Model state and register copies.
    logic [15:0] m_tstart, m_tend, m_vstart, m_vend, m_astart, m_afull, m_period;
    logic [16:0] m_afrac;
    longint      acc_temp, acc_curr, acc_volt;
    longint      m_duty, m_ceil, m_ticks;

    duty_result_t expected_q[$];
    int  fail_count;
    longint cycles;
    bit  quiet;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic longint floor_shift16(longint x);
        return x >>> 16;
    endfunction

    function automatic longint filter_step(longint acc, longint smp, longint k);
        return acc - floor_shift16((acc - smp * 65536) * k);
    endfunction

    function automatic longint temp_factor_now();
        longint s, e;
        s = longint'($signed(m_tstart)) * 65536;
        e = longint'($signed(m_tend)) * 65536;
        if (acc_temp < s) return 65536;
        if (acc_temp > e) return 0;
        if (e == s) return 65536;
        return ((e - acc_temp) * 65536) / (e - s);
    endfunction

    function automatic longint volt_factor_now();
        longint s, e;
        s = longint'(m_vstart) * 65536;
        e = longint'(m_vend) * 65536;
        if (acc_volt > s) return 65536;
        if (acc_volt < e) return 0;
        if (e == s) return 65536;
        return ((acc_volt - e) * 65536) / (s - e);
    endfunction

    function automatic void apply_duty(longint d);
        m_duty = (d > m_ceil) ? m_ceil : d;
        m_ticks = 0;
    endfunction

    function automatic duty_result_t predict_duty(logic cmd, logic signed [15:0] ta,
            logic signed [15:0] tb, logic signed [15:0] tc, logic signed [15:0] cur,
            logic [15:0] volt, logic [16:0] man);
        duty_result_t r;
        longint t, tf, vf, a0, a1, f, val;
        if (cmd == 1'b0) begin
            t = ta;
            if (tb > t) t = tb;
            if (tc > t) t = tc;
            acc_temp = filter_step(acc_temp, t, 3277);
            acc_curr = filter_step(acc_curr, longint'(cur), 655);
            acc_volt = filter_step(acc_volt, longint'(volt), 32768);
            tf = temp_factor_now();
            vf = volt_factor_now();
            m_ceil = (tf < vf) ? tf : vf;
            m_ticks++;
            if (m_duty > m_ceil) apply_duty(m_ceil);
            if (m_ticks > TIMEOUT_TICKS) apply_duty(0);
            a0 = longint'(m_astart) * 65536;
            a1 = longint'(m_afull) * 65536;
            f = m_afrac;
            if (f >= 1311 && acc_volt >= a0) begin
                if (acc_volt > a1 || a1 == a0) val = f;
                else val = ((acc_volt - a0) * f) / (a1 - a0);
                if (val > 0) apply_duty(val);
            end
        end else begin
            apply_duty(longint'(man));
            tf = temp_factor_now();
        end
        r.cmp  = 16'((longint'(m_period) * m_duty) >> 16);
        r.duty = 17'(m_duty);
        r.lim  = 17'(m_ceil);
        r.ot   = (tf * 10 < 9 * 65536);
        r.act  = (m_duty * 1000 > 65536);
        r.cur  = 16'(acc_curr >>> 16);
        r.volt = 16'(acc_volt >>> 16);
        r.temp = 16'(acc_temp >>> 16);
        return r;
    endfunction

    // Result side: random stall bursts, compare each accepted result.
    initial begin
        int gap;
        result_stall = 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (!quiet && $urandom_range(0, 9) == 0) begin
                gap = $urandom_range(1, 7);
                result_stall <= 1'b1;
                repeat (gap) @(posedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        duty_result_t e;
        if (rst_n && result_valid && !result_stall) begin
            if (expected_q.size() == 0) begin
                $error("result with no request outstanding");
                fail_count++;
            end else begin
                e = expected_q.pop_front();
                if (compare_value !== e.cmp) begin
                    $error("compare_value exp %0d got %0d", e.cmp, compare_value);
                    fail_count++;
                end
                if (duty_now !== e.duty) begin
                    $error("duty_now exp %0d got %0d", e.duty, duty_now);
                    fail_count++;
                end
                if (duty_limit !== e.lim) begin
                    $error("duty_limit exp %0d got %0d", e.lim, duty_limit);
                    fail_count++;
                end
                if (over_temp_led !== e.ot) begin
                    $error("over_temp_led exp %0d got %0d", e.ot, over_temp_led);
                    fail_count++;
                end
                if (active_led !== e.act) begin
                    $error("active_led exp %0d got %0d", e.act, active_led);
                    fail_count++;
                end
                if (current_filtered !== e.cur) begin
                    $error("current_filtered exp %0d got %0d", $signed(e.cur),
                           current_filtered);
                    fail_count++;
                end
                if (voltage_filtered !== e.volt) begin
                    $error("voltage_filtered exp %0d got %0d", e.volt, voltage_filtered);
                    fail_count++;
                end
                if (temp_filtered !== e.temp) begin
                    $error("temp_filtered exp %0d got %0d", $signed(e.temp), temp_filtered);
                    fail_count++;
                end
            end
        end
    end

    task automatic send_request(logic cmd, logic signed [15:0] ta, logic signed [15:0] tb,
            logic signed [15:0] tc, logic signed [15:0] cur, logic [15:0] volt,
            logic [16:0] man);
        int gap;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 7);
            repeat (gap) @(posedge clk);
        end
        item_valid    <= 1'b1;
        command       <= cmd;
        temp_a        <= ta;
        temp_b        <= tb;
        temp_c        <= tc;
        input_current <= cur;
        input_voltage <= volt;
        manual_duty   <= man;
        @(posedge clk);
        while (item_stall) @(posedge clk);
        expected_q.push_back(predict_duty(cmd, ta, tb, tc, cur, volt, man));
        item_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        while (expected_q.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_TEMP_START: m_tstart = val[15:0];
            REG_TEMP_END:   m_tend   = val[15:0];
            REG_VOLT_START: m_vstart = val[15:0];
            REG_VOLT_END:   m_vend   = val[15:0];
            REG_AUTO_START: m_astart = val[15:0];
            REG_AUTO_FULL:  m_afull  = val[15:0];
            REG_AUTO_FRAC:  m_afrac  = val[16:0];
            default:        m_period = val[15:0];
        endcase
    endtask

    function automatic logic signed [15:0] rand_temp();
        case ($urandom_range(0, 3))
            0: return 16'(int'($urandom_range(0, 34815)) - 2048);
            1: return $urandom_range(0, 1) ? 16'sh7FFF : -16'sd2048;
            default: return 16'(int'($urandom_range(1000, 1900)));
        endcase
    endfunction

    task automatic send_tick(logic [15:0] vlo, logic [15:0] vhi);
        send_request(1'b0, rand_temp(), rand_temp(), rand_temp(), 16'($urandom),
                     16'($urandom_range(vlo, vhi)), 17'($urandom));
    endtask

    task automatic send_manual();
        logic [16:0] d;
        d = $urandom_range(0, 3) == 0 ? 17'h10000 : 17'($urandom_range(0, 131071));
        send_request(1'b1, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom), d);
    endtask

    task automatic test_directed_extremes();
        send_request(1'b1, 0, 0, 0, 0, 0, 17'h10000);
        send_request(1'b0, 16'sh7FFF, -16'sd2048, 0, 16'sh7FFF, 16'hFFFF, 0);
        send_request(1'b0, -16'sd2048, 16'sh7FFF, -16'sd2048, -16'sh8000, 16'hFFFF, 0);
        send_request(1'b0, 0, 0, 16'sh7FFF, -16'sh8000, 0, 0);
        send_request(1'b1, 0, 0, 0, 0, 0, 17'h1FFFF);
        send_request(1'b1, 0, 0, 0, 0, 0, 17'd0);
        for (int i = 0; i < 8; i++)
            send_request(1'b0, -16'sd2048, -16'sd2048, -16'sd2048, 0, 16'd1400, 0);
        send_request(1'b1, 0, 0, 0, 0, 0, 17'h10000);
        send_request(1'b0, 16'd1500, 0, 0, 0, 16'd1100, 0);
        drain();
    endtask

    task automatic test_equal_curve_ends();
        write_reg(REG_TEMP_START, 32'd1400);
        write_reg(REG_TEMP_END, 32'd1400);
        write_reg(REG_VOLT_START, 32'd1000);
        write_reg(REG_VOLT_END, 32'd1000);
        write_reg(REG_PWM_PERIOD, 32'hFFFF);
        for (int i = 0; i < 10; i++) begin
            send_tick(16'd900, 16'd1100);
            send_manual();
        end
        drain();
    endtask

    task automatic test_auto_mode();
        write_reg(REG_TEMP_START, 32'h8000);
        write_reg(REG_TEMP_END, 32'h7FFF);
        write_reg(REG_VOLT_START, 32'd0);
        write_reg(REG_VOLT_END, 32'd0);
        write_reg(REG_AUTO_START, 32'd2000);
        write_reg(REG_AUTO_FULL, 32'd3000);
        write_reg(REG_AUTO_FRAC, 32'h10000);
        write_reg(REG_PWM_PERIOD, 32'd1);
        for (int i = 0; i < 150; i++)
            if ($urandom_range(0, 5) == 0) send_manual();
            else send_tick(16'd1500, 16'd3500);
        drain();
        write_reg(REG_AUTO_FRAC, 32'd1311);
        write_reg(REG_AUTO_FULL, 32'd2000);
        for (int i = 0; i < 40; i++) send_tick(16'd1500, 16'd3500);
        drain();
        write_reg(REG_AUTO_FRAC, 32'd1310);
        write_reg(REG_AUTO_FULL, 32'hFFFF);
        write_reg(REG_AUTO_START, 32'hFFFF);
        for (int i = 0; i < 20; i++) send_tick(16'd0, 16'hFFFF);
        drain();
    endtask

    // A full manual duty followed by a long run of ticks with no set.
    task automatic test_duty_hold();
        write_reg(REG_AUTO_FRAC, 32'd0);
        write_reg(REG_TEMP_START, 32'd1280);
        write_reg(REG_TEMP_END, 32'd1600);
        write_reg(REG_VOLT_START, 32'd1280);
        write_reg(REG_VOLT_END, 32'd960);
        write_reg(REG_PWM_PERIOD, 32'd1066);
        send_request(1'b1, 0, 0, 0, 0, 0, 17'h10000);
        for (int i = 0; i < HOLD_TICKS; i++)
            send_request(1'b0, 16'd100, 16'd200, -16'sd5, 16'($urandom), 16'd2000, 0);
        drain();
    endtask

    task automatic test_random_mix();
        for (int i = 0; i < 400; i++) begin
            if (i == 200) begin
                drain();
                write_reg(REG_TEMP_START, 32'($urandom_range(0, 1600)));
                write_reg(REG_TEMP_END, 32'($urandom_range(1600, 3000)));
                write_reg(REG_VOLT_START, 32'($urandom_range(1000, 2000)));
                write_reg(REG_VOLT_END, 32'($urandom_range(0, 1000)));
                write_reg(REG_AUTO_START, 32'd1500);
                write_reg(REG_AUTO_FULL, 32'd2500);
                write_reg(REG_AUTO_FRAC, 32'($urandom_range(0, 65536)));
                write_reg(REG_PWM_PERIOD, 32'($urandom_range(1, 65535)));
            end
            if (i == 330) quiet = 1'b1;
            if ($urandom_range(0, 3) == 0) send_manual();
            else send_tick(16'd0, $urandom_range(0, 1) ? 16'd3000 : 16'hFFFF);
        end
        drain();
    endtask

    initial begin
        clk = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        item_valid = 1'b0; command = 1'b0;
        temp_a = '0; temp_b = '0; temp_c = '0; input_current = '0;
        input_voltage = '0; manual_duty = '0;
        cycles = 0; fail_count = 0; quiet = 1'b0;
        m_tstart = 16'd1280; m_tend = 16'd1600; m_vstart = 16'd1280; m_vend = 16'd960;
        m_astart = 0; m_afull = 0; m_afrac = 0; m_period = 16'd1066;
        acc_temp = 0; acc_curr = 0; acc_volt = 0;
        m_duty = 0; m_ceil = 65536; m_ticks = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_extremes();
        test_equal_curve_ends();
        test_auto_mode();
        test_duty_hold();
        test_random_mix();
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire

/* brake_chopper_duty_control_top.f */
sv/bcdc_pkg.sv
sv/bcdc_div.sv
sv/bcdc_dpath.sv
sv/bcdc_ctrl.sv
sv/brake_chopper_duty_control_top.sv
bench/brake_chopper_duty_control_top_tb.sv
